>>> rtl/core/lrbf_pkg.sv
// Shared types, constants and CRC32C helpers for the log record block framer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lrbf_pkg;

	// Log geometry (block size is a power of two)
	localparam int BLOCK_SIZE  = 32768;
	localparam int HEADER_SIZE = 7;

	// Field and state widths
	localparam int OFF_W  = $clog2(BLOCK_SIZE);
	localparam int POS_W  = 48;
	localparam int REC_W  = 32;
	localparam int BYTE_W = 8;
	localparam int PAD_W  = 3;
	localparam int TYPE_W = 3;
	localparam int FRAG_W = 15;
	localparam int CRC_W  = 32;

	// Offset arithmetic constants
	localparam logic [OFF_W:0]   BLOCK_LEN = (OFF_W + 1)'(BLOCK_SIZE);
	localparam logic [OFF_W:0]   HDR_LEN   = (OFF_W + 1)'(HEADER_SIZE);
	localparam logic [OFF_W-1:0] AVAIL_MAX = OFF_W'(BLOCK_SIZE - HEADER_SIZE);

	// CRC32C (reflected Castagnoli polynomial) and the log format mask
	localparam logic [CRC_W-1:0] CRC_POLY     = 32'h82f6_3b78;
	localparam logic [CRC_W-1:0] CRC_INIT     = 32'hffff_ffff;
	localparam logic [CRC_W-1:0] CRC_MASK_ADD = 32'ha282_ead8;

	// Command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_BYTE  = 1'b1;

	// Fragment types; NONE marks no fragment set up
	typedef enum logic [TYPE_W-1:0] {
		FRAG_NONE   = 3'd0,
		FRAG_FULL   = 3'd1,
		FRAG_FIRST  = 3'd2,
		FRAG_MIDDLE = 3'd3,
		FRAG_LAST   = 3'd4
	} frag_type_t;

	// One input item
	typedef struct packed {
		logic              cmd;
		logic [REC_W-1:0]  rec_len;
		logic [BYTE_W-1:0] data;
	} item_t;

	// One fragment descriptor
	typedef struct packed {
		logic [PAD_W-1:0]  pad;
		logic [POS_W-1:0]  hdr_off;
		frag_type_t        ftype;
		logic [FRAG_W-1:0] flen;
		logic [CRC_W-1:0]  crc;
		logic              done;
	} frag_res_t;

	// Fold one byte into a running CRC32C
	function automatic logic [CRC_W-1:0] crc32c_byte(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W - BYTE_W){1'b0}}, b};
		for (int i = 0; i < BYTE_W; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// CRC state after the type byte of a fresh fragment
	function automatic logic [CRC_W-1:0] type_seed(input frag_type_t t);
		return crc32c_byte(CRC_INIT, BYTE_W'(t));
	endfunction

	// Finalise and mask: rotate right by 15, add the format constant
	function automatic logic [CRC_W-1:0] crc_mask(input logic [CRC_W-1:0] crc);
		logic [CRC_W-1:0] x;
		x = crc ^ CRC_INIT;
		return {x[14:0], x[31:15]} + CRC_MASK_ADD;
	endfunction

endpackage

>>> rtl/core/lrbf_in_stage.sv
// Input register of the framer: captures one item and holds it while the
// result side is blocked. Depends on lrbf_pkg.
`timescale 1ns / 1ps

module lrbf_in_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [lrbf_pkg::REC_W-1:0]    record_length,
	input  logic [lrbf_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          busy,
	output logic                          valid_s1,
	output lrbf_pkg::item_t               item_s1
);
	import lrbf_pkg::*;

	// Stall only when an item is held and cannot advance
	assign in_stall = valid_s1 && busy;

	// Track occupancy of the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Load the payload on every accepted item
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.cmd     <= cmd;
			item_s1.rec_len <= record_length;
			item_s1.data    <= data_byte;
		end
	end

endmodule

>>> rtl/core/lrbf_framer.sv
// Fragmentation state and per-item update: block offset, log position,
// record and fragment counters and running CRC32C. Depends on lrbf_pkg.
`timescale 1ns / 1ps

module lrbf_framer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_enable,
	input  logic [lrbf_pkg::POS_W-1:0]  cfg_write_data,
	input  logic                        step,
	input  lrbf_pkg::item_t             item_s1,
	output logic                        emit,
	output lrbf_pkg::frag_res_t         res
);
	import lrbf_pkg::*;

	logic [OFF_W-1:0] off_q, off_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [REC_W-1:0] rec_q, rec_d;
	logic [OFF_W-1:0] fl_q, fl_d;
	logic [OFF_W-1:0] len_q, len_d;
	frag_type_t       type_q, type_d;
	logic [CRC_W-1:0] crc_q, crc_d;
	logic [PAD_W-1:0] pad_q, pad_d;
	logic [POS_W-1:0] hdr_q, hdr_d;

	// Start command: place the first fragment
	logic [OFF_W:0]   leftover;
	logic             tail_pad;
	logic [PAD_W-1:0] st_pad;
	logic [OFF_W-1:0] st_base;
	logic [POS_W-1:0] st_hdr;
	logic [OFF_W-1:0] st_avail;
	logic             st_fits;
	logic [OFF_W-1:0] st_frag;
	frag_type_t       st_type;
	logic [OFF_W:0]   st_sum;
	logic [OFF_W-1:0] st_off;
	logic [POS_W-1:0] st_pos;

	assign leftover = BLOCK_LEN - {1'b0, off_q};
	assign tail_pad = leftover < HDR_LEN;
	assign st_pad   = tail_pad ? leftover[PAD_W-1:0] : '0;
	assign st_base  = tail_pad ? '0 : off_q;
	assign st_hdr   = pos_q + POS_W'(st_pad);
	assign st_avail = AVAIL_MAX - st_base;
	assign st_fits  = item_s1.rec_len <= REC_W'(st_avail);
	assign st_frag  = st_fits ? OFF_W'(item_s1.rec_len) : st_avail;
	assign st_type  = st_fits ? FRAG_FULL : FRAG_FIRST;
	assign st_sum   = {1'b0, st_base} + HDR_LEN;
	assign st_off   = (st_sum >= BLOCK_LEN) ? '0 : st_sum[OFF_W-1:0];
	assign st_pos   = st_hdr + POS_W'(HEADER_SIZE);

	// Payload byte: advance the CRC and counters, close the fragment
	logic [CRC_W-1:0] py_crc;
	logic [REC_W-1:0] py_rec;
	logic [OFF_W-1:0] py_base;
	logic [OFF_W:0]   py_sum;
	logic [OFF_W-1:0] py_off;
	logic [POS_W-1:0] py_pos;

	assign py_crc  = crc32c_byte(crc_q, item_s1.data);
	assign py_rec  = rec_q - REC_W'(1);
	assign py_base = (pad_q != '0) ? '0 : off_q;
	assign py_sum  = {1'b0, py_base} + HDR_LEN + {1'b0, len_q};
	assign py_off  = (py_sum >= BLOCK_LEN) ? '0 : py_sum[OFF_W-1:0];
	assign py_pos  = hdr_q + POS_W'(HEADER_SIZE) + POS_W'(len_q);

	// Follow-on fragment: always starts at the head of a fresh block
	logic [REC_W-1:0] nx_rec;
	logic             nx_fits;
	logic [OFF_W-1:0] nx_frag;
	frag_type_t       nx_type;

	assign nx_rec  = (item_s1.cmd == CMD_START) ? item_s1.rec_len : py_rec;
	assign nx_fits = nx_rec <= REC_W'(AVAIL_MAX);
	assign nx_frag = nx_fits ? OFF_W'(nx_rec) : AVAIL_MAX;
	assign nx_type = nx_fits ? FRAG_LAST : FRAG_MIDDLE;

	// Next state and descriptor
	always_comb begin
		off_d  = off_q;
		pos_d  = pos_q;
		rec_d  = rec_q;
		fl_d   = fl_q;
		len_d  = len_q;
		type_d = type_q;
		crc_d  = crc_q;
		pad_d  = pad_q;
		hdr_d  = hdr_q;
		emit   = 1'b0;
		res    = '0;
		if (cfg_write_enable) begin
			// reopen the log: new position, drop any record
			pos_d  = cfg_write_data;
			off_d  = cfg_write_data[OFF_W-1:0];
			rec_d  = '0;
			fl_d   = '0;
			len_d  = '0;
			type_d = FRAG_NONE;
			crc_d  = CRC_INIT;
			pad_d  = '0;
			hdr_d  = '0;
		end else if (step) begin
			if (item_s1.cmd == CMD_START) begin
				rec_d  = item_s1.rec_len;
				fl_d   = st_frag;
				len_d  = st_frag;
				type_d = st_type;
				crc_d  = type_seed(st_type);
				pad_d  = st_pad;
				hdr_d  = st_hdr;
				if (st_frag == '0) begin
					// empty record or header alone at the block tail
					emit        = 1'b1;
					res.pad     = st_pad;
					res.hdr_off = st_hdr;
					res.ftype   = st_type;
					res.flen    = '0;
					res.crc     = crc_mask(type_seed(st_type));
					res.done    = st_fits;
					pos_d       = st_pos;
					off_d       = st_off;
					if (st_fits) begin
						rec_d  = '0;
						fl_d   = '0;
						len_d  = '0;
						type_d = FRAG_NONE;
						crc_d  = CRC_INIT;
						pad_d  = '0;
						hdr_d  = '0;
					end else begin
						fl_d   = nx_frag;
						len_d  = nx_frag;
						type_d = nx_type;
						crc_d  = type_seed(nx_type);
						pad_d  = '0;
						hdr_d  = st_pos;
					end
				end
			end else if (rec_q != '0 && fl_q != '0) begin
				crc_d = py_crc;
				rec_d = py_rec;
				fl_d  = fl_q - OFF_W'(1);
				if (fl_q == OFF_W'(1)) begin
					emit        = 1'b1;
					res.pad     = pad_q;
					res.hdr_off = hdr_q;
					res.ftype   = type_q;
					res.flen    = FRAG_W'(len_q);
					res.crc     = crc_mask(py_crc);
					res.done    = (type_q == FRAG_FULL) || (type_q == FRAG_LAST);
					pos_d       = py_pos;
					off_d       = py_off;
					if (py_rec != '0) begin
						fl_d   = nx_frag;
						len_d  = nx_frag;
						type_d = nx_type;
						crc_d  = type_seed(nx_type);
						pad_d  = '0;
						hdr_d  = py_pos;
					end else begin
						fl_d   = '0;
						len_d  = '0;
						type_d = FRAG_NONE;
						crc_d  = CRC_INIT;
						pad_d  = '0;
						hdr_d  = '0;
					end
				end
			end
		end
	end

	// Hold the framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			pos_q  <= '0;
			rec_q  <= '0;
			fl_q   <= '0;
			len_q  <= '0;
			type_q <= FRAG_NONE;
			crc_q  <= CRC_INIT;
			pad_q  <= '0;
			hdr_q  <= '0;
		end else begin
			off_q  <= off_d;
			pos_q  <= pos_d;
			rec_q  <= rec_d;
			fl_q   <= fl_d;
			len_q  <= len_d;
			type_q <= type_d;
			crc_q  <= crc_d;
			pad_q  <= pad_d;
			hdr_q  <= hdr_d;
		end
	end

endmodule

>>> rtl/core/lrbf_out_stage.sv
// Result register of the framer: holds one descriptor until the receiver
// takes it. Depends on lrbf_pkg.
`timescale 1ns / 1ps

module lrbf_out_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  lrbf_pkg::frag_res_t          res,
	output logic                         busy,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lrbf_pkg::PAD_W-1:0]   pad_bytes,
	output logic [lrbf_pkg::POS_W-1:0]   header_offset,
	output logic [lrbf_pkg::TYPE_W-1:0]  fragment_type,
	output logic [lrbf_pkg::FRAG_W-1:0]  frag_length,
	output logic [lrbf_pkg::CRC_W-1:0]   masked_crc,
	output logic                         record_done
);
	import lrbf_pkg::*;

	frag_res_t res_q;

	// Blocked while a descriptor waits on a stalled receiver
	assign busy = out_valid && out_stall;

	// Track occupancy of the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Load a new descriptor
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign pad_bytes     = res_q.pad;
	assign header_offset = res_q.hdr_off;
	assign fragment_type = res_q.ftype;
	assign frag_length   = res_q.flen;
	assign masked_crc    = res_q.crc;
	assign record_done   = res_q.done;

endmodule

>>> rtl/core/log_record_block_framer_core.sv
// Top level of the log record block framer: input register, framing state
// and result register. Depends on lrbf_pkg, lrbf_in_stage, lrbf_framer and
// lrbf_out_stage.
//
// Usage:
//   Input channel (in_valid / in_stall): cmd 0 starts a record of
//   record_length payload bytes; cmd 1 carries one payload byte in
//   data_byte. Output channel (out_valid / out_stall): one fragment
//   descriptor per completed fragment - padding before the header, header
//   log offset, type, length, masked CRC32C and a record-complete flag.
//   A start with length zero, or one landing with exactly a header's room
//   left in the block, yields a descriptor at once.
//   Configuration: cfg_write_enable with cfg_write_data sets the existing
//   log length and drops any record in progress; write it only when idle.
// Timing:
//   One item per cycle sustained while no descriptor is stalled. The item that
//   closes a fragment passes the input register, then its descriptor is
//   loaded into the result register; the CRC byte update and the offset
//   adders lie combinationally between the two registers.
// Reset:
//   arst_n clears the log position to zero and drops any record.
// Stall:
//   While a descriptor waits on out_stall, the held input item waits too
//   and in_stall rises once the input register is occupied.
`timescale 1ns / 1ps

module log_record_block_framer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_enable,
	input  logic [lrbf_pkg::POS_W-1:0]   cfg_write_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic [lrbf_pkg::REC_W-1:0]   record_length,
	input  logic [lrbf_pkg::BYTE_W-1:0]  data_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lrbf_pkg::PAD_W-1:0]   pad_bytes,
	output logic [lrbf_pkg::POS_W-1:0]   header_offset,
	output logic [lrbf_pkg::TYPE_W-1:0]  fragment_type,
	output logic [lrbf_pkg::FRAG_W-1:0]  frag_length,
	output logic [lrbf_pkg::CRC_W-1:0]   masked_crc,
	output logic                         record_done
);
	import lrbf_pkg::*;

	logic      busy;
	logic      valid_s1;
	item_t     item_s1;
	logic      step;
	logic      emit;
	frag_res_t res;

	// Advance the held item whenever the result side can take a descriptor
	assign step = valid_s1 && !busy;

	lrbf_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.record_length (record_length),
		.data_byte     (data_byte),
		.busy          (busy),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	lrbf_framer u_framer (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_write_data   (cfg_write_data),
		.step             (step),
		.item_s1          (item_s1),
		.emit             (emit),
		.res              (res)
	);

	lrbf_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (step && emit),
		.res           (res),
		.busy          (busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pad_bytes     (pad_bytes),
		.header_offset (header_offset),
		.fragment_type (fragment_type),
		.frag_length   (frag_length),
		.masked_crc    (masked_crc),
		.record_done   (record_done)
	);

endmodule

>>> rtl/core/lrbf_checker.sv
// Port-level checks for the log record block framer, bound to the top
// level. Depends on lrbf_pkg and log_record_block_framer_core.
`timescale 1ns / 1ps

module lrbf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [lrbf_pkg::PAD_W-1:0]   pad_bytes,
	input logic [lrbf_pkg::POS_W-1:0]   header_offset,
	input logic [lrbf_pkg::TYPE_W-1:0]  fragment_type,
	input logic [lrbf_pkg::FRAG_W-1:0]  frag_length,
	input logic [lrbf_pkg::CRC_W-1:0]   masked_crc,
	input logic                         record_done
);
	import lrbf_pkg::*;

	// Hold a stalled descriptor unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(header_offset)
			&& $stable(masked_crc) && $stable(frag_length))
		else $error("stalled descriptor changed");

	// Back-pressure on the input only comes from a stalled descriptor
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked descriptor");

	// Record-complete flag follows the fragment type
	a_done_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (record_done == ((fragment_type == FRAG_FULL)
			|| (fragment_type == FRAG_LAST)))
			&& (fragment_type != FRAG_NONE))
		else $error("record_done does not match fragment type");

	// A middle fragment fills a whole block after its header
	a_middle_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fragment_type == FRAG_MIDDLE |->
			frag_length == FRAG_W'(BLOCK_SIZE - HEADER_SIZE) && pad_bytes == '0)
		else $error("middle fragment does not fill its block");

endmodule

bind log_record_block_framer_core lrbf_checker u_lrbf_checker (.*);
